// ===== src/owik_pkg.sv =====
// ----------------------------------------------------------------------------
// owik_pkg
// types, constants and the cordic arctangent table for the wheel kinematics
// ----------------------------------------------------------------------------
`default_nettype none

package owik_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int DIV_BITS = 24;
  // stage 0, cordic steps, four arithmetic stages, divider, output register
  localparam int LATENCY = NSTEP + 6 + DIV_BITS;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [26:0] RPM_SCALE = 27'sd39113919;
  localparam logic signed [23:0] OUT_MAX = 24'sh7fffff;
  localparam logic signed [23:0] OUT_MIN = 24'sh800000;

  localparam logic [2:0] REG_ANGLE_0 = 3'd0;
  localparam logic [2:0] REG_ANGLE_1 = 3'd1;
  localparam logic [2:0] REG_ANGLE_2 = 3'd2;
  localparam logic [2:0] REG_ANGLE_3 = 3'd3;
  localparam logic [2:0] REG_CENTER_DIST = 3'd4;
  localparam logic [2:0] REG_RADIUS = 3'd5;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic [15:0]        heading;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] rpm_0;
    logic signed [23:0] rpm_1;
    logic signed [23:0] rpm_2;
    logic signed [23:0] rpm_3;
  } rpm_t;

  function automatic logic [29:0] atan_turn(input int i);
    logic [29:0] r;
    case (i)
      0: r = 30'd536870912;
      1: r = 30'd316933406;
      2: r = 30'd167458907;
      3: r = 30'd85004756;
      4: r = 30'd42667331;
      5: r = 30'd21354465;
      6: r = 30'd10679838;
      7: r = 30'd5340245;
      8: r = 30'd2670163;
      9: r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/owik_lane.sv =====
// ----------------------------------------------------------------------------
// owik_lane
// one wheel: pipelined cordic, velocity projection, rpm scaling and a
// one-bit-per-stage divider by the wheel radius, saturated to 24 bits
// ----------------------------------------------------------------------------
`default_nettype none

module owik_lane import owik_pkg::*; (
  input  wire                logic               clk,
  input  wire                logic               en,
  input  wire                logic [15:0]        angle,
  input  wire                logic [15:0]        heading,
  input  wire                logic signed [15:0] vel_x,
  input  wire                logic signed [15:0] vel_y,
  input  wire                logic signed [15:0] turn_rate,
  input  wire                logic [15:0]        center_distance,
  input  wire                logic [15:0]        wheel_radius,
  output logic signed [23:0] rpm
);

  logic signed [32:0] cx [NSTEP+1];
  logic signed [32:0] cy [NSTEP+1];
  logic signed [33:0] cz [NSTEP+1];
  logic               cflip [NSTEP+1];
  logic signed [15:0] cvx [NSTEP+1];
  logic signed [15:0] cvy [NSTEP+1];
  logic signed [15:0] cw [NSTEP+1];

  logic [15:0]        ang_sum;
  logic signed [16:0] ang_s;
  logic signed [16:0] ang_fold;
  logic               ang_flip;

  // fold the angle into the right half plane
  always_comb begin
    ang_sum = angle + heading;
    ang_s = {ang_sum[15], ang_sum};
    ang_flip = 1'b0;
    ang_fold = ang_s;
    if (ang_s > 17'sd16384) begin
      ang_fold = ang_s - 17'sd32768;
      ang_flip = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      ang_fold = ang_s + 17'sd32768;
      ang_flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= {ang_fold[16], ang_fold, 16'h0000};
      cflip[0] <= ang_flip;
      cvx[0] <= vel_x;
      cvy[0] <= vel_y;
      cw[0] <= turn_rate;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][33]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed(34'(atan_turn(i)));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed(34'(atan_turn(i)));
        end
        cflip[i+1] <= cflip[i];
        cvx[i+1] <= cvx[i];
        cvy[i+1] <= cvy[i];
        cw[i+1] <= cw[i];
      end
    end
  end

  // projection products
  logic signed [48:0] prod_s;
  logic signed [48:0] prod_c;
  logic signed [32:0] prod_w;
  logic               p_flip;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_s <= cy[NSTEP] * cvx[NSTEP];
      prod_c <= cx[NSTEP] * cvy[NSTEP];
      prod_w <= $signed({1'b0, center_distance}) * cw[NSTEP];
      p_flip <= cflip[NSTEP];
    end
  end

  // wheel surface speed, cut to 20 fraction bits
  logic signed [51:0] s38;
  logic signed [51:0] s38_r;
  logic signed [33:0] s20;

  always_comb begin
    if (p_flip) begin
      s38 = 52'(prod_s) - 52'(prod_c) + (52'(prod_w) <<< 18);
    end else begin
      s38 = 52'(prod_c) - 52'(prod_s) + (52'(prod_w) <<< 18);
    end
    s38_r = (s38 + 52'sd131072) >>> 18;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s20 <= s38_r[33:0];
    end
  end

  logic signed [60:0] scaled;

  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= s20 * RPM_SCALE;
    end
  end

  // rounding offset and division by 2^24, leaving division by the radius
  logic [15:0] rad;
  logic [60:0] mag;
  logic [60:0] num_full;
  logic [36:0] num;

  always_comb begin
    rad = (wheel_radius == 16'd0) ? 16'd1 : wheel_radius;
    mag = scaled[60] ? 61'(-scaled) : 61'(scaled);
    num_full = mag + {22'd0, rad, 23'd0};
    num = num_full[60:24];
  end

  logic [16:0]         drem [DIV_BITS+1];
  logic [DIV_BITS-1:0] dquo [DIV_BITS+1];
  logic [DIV_BITS-1:0] dlow [DIV_BITS+1];
  logic                dneg [DIV_BITS+1];
  logic                dsat [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= {4'd0, num[36:24]};
      dquo[0] <= '0;
      dlow[0] <= num[23:0];
      dneg[0] <= scaled[60];
      dsat[0] <= ({3'd0, num[36:24]} >= rad);
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [16:0] trial;
    assign trial = {drem[j][15:0], dlow[j][DIV_BITS-1-j]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, rad}) begin
          drem[j+1] <= trial - {1'b0, rad};
          dquo[j+1] <= {dquo[j][DIV_BITS-2:0], 1'b1};
        end else begin
          drem[j+1] <= trial;
          dquo[j+1] <= {dquo[j][DIV_BITS-2:0], 1'b0};
        end
        dlow[j+1] <= dlow[j];
        dneg[j+1] <= dneg[j];
        dsat[j+1] <= dsat[j];
      end
    end
  end

  logic [DIV_BITS-1:0] quo;
  logic signed [23:0]  rpm_next;

  always_comb begin
    quo = dquo[DIV_BITS];
    if (!dneg[DIV_BITS]) begin
      if (dsat[DIV_BITS] || quo > 24'd8388607) begin
        rpm_next = OUT_MAX;
      end else begin
        rpm_next = $signed(quo);
      end
    end else begin
      if (dsat[DIV_BITS] || quo > 24'd8388608) begin
        rpm_next = OUT_MIN;
      end else begin
        rpm_next = -$signed(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rpm <= rpm_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/omni_wheel_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics
// Body velocity and heading in, four wheel speeds in RPM out.
// A command beat on cmd is taken when cmd_valid is high and cmd_stall low;
// a result beat on rpm leaves when rpm_valid is high and rpm_stall low.
// One result beat follows every command beat, in order.
// The pipeline has CORDIC_STEPS + 30 register stages (46 at 16 steps): one
// angle stage, one cordic step per stage, four arithmetic stages, a 24-stage
// divider by the wheel radius and the output register, which presents each
// beat on rpm. Throughput is one beat per cycle while no result is stalled;
// every stage is a register with the valid bit traveling alongside.
// When the result beat is stalled the whole pipeline holds and cmd_stall
// rises; nothing is lost or repeated.
// Registers are written on cfg_we with cfg_index / cfg_data; the user must
// write them between commands only, the block itself does not enforce it.
// Reset empties the pipeline and restores the default wheel angles,
// center distance and radius.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_inverse_kinematics import owik_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_we,
  input  wire  logic [2:0]  cfg_index,
  input  wire  logic [15:0] cfg_data,
  input  wire  logic        cmd_valid,
  output logic              cmd_stall,
  input  wire  cmd_t        cmd,
  output logic              rpm_valid,
  input  wire  logic        rpm_stall,
  output rpm_t              rpm
);

  logic [15:0] wheel_angle [4];
  logic [15:0] center_distance;
  logic [15:0] wheel_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_angle[0] <= 16'd8192;
      wheel_angle[1] <= 16'd24576;
      wheel_angle[2] <= 16'd40960;
      wheel_angle[3] <= 16'd57344;
      center_distance <= 16'd256;
      wheel_radius <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_0: wheel_angle[0] <= cfg_data;
        REG_ANGLE_1: wheel_angle[1] <= cfg_data;
        REG_ANGLE_2: wheel_angle[2] <= cfg_data;
        REG_ANGLE_3: wheel_angle[3] <= cfg_data;
        REG_CENTER_DIST: center_distance <= cfg_data;
        REG_RADIUS: wheel_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  logic               en;
  logic [LATENCY-1:0] valid;

  assign en = !(valid[LATENCY-1] && rpm_stall);
  assign cmd_stall = !en;
  assign rpm_valid = valid[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[LATENCY-2:0], cmd_valid};
    end
  end

  logic signed [23:0] lane_rpm [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    owik_lane u_lane (
      .clk             (clk),
      .en              (en),
      .angle           (wheel_angle[k]),
      .heading         (cmd.heading),
      .vel_x           (cmd.vel_x),
      .vel_y           (cmd.vel_y),
      .turn_rate       (cmd.turn_rate),
      .center_distance (center_distance),
      .wheel_radius    (wheel_radius),
      .rpm             (lane_rpm[k])
    );
  end

  assign rpm.rpm_0 = lane_rpm[0];
  assign rpm.rpm_1 = lane_rpm[1];
  assign rpm.rpm_2 = lane_rpm[2];
  assign rpm.rpm_3 = lane_rpm[3];

endmodule

`default_nettype wire

// ===== verif/tb_omni_wheel_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// tb_omni_wheel_inverse_kinematics
// Drives velocity commands with random bursts and gaps, stalls the result
// side on its own pattern, and checks every wheel speed against a cordic
// and fixed-point predictor kept in the testbench, over several register
// settings including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_omni_wheel_inverse_kinematics;
  import owik_pkg::*;

  localparam int ATAN_N = 24;
  localparam int RPM_MAX = 8388607;
  localparam int RPM_MIN = -8388608;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint SCALE_Q16 = 39113919;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        rpm_valid;
  logic        rpm_stall;
  rpm_t        rpm;

  logic [15:0] wheel_angle [4];
  logic [15:0] center_dist;
  logic [15:0] radius;
  rpm_t        expected_rpm [$];
  int          errors;
  int          beats_sent;
  int          beats_checked;
  int          burst_left;
  bit          stall_hold;
  longint      atan_tab [ATAN_N];

  omni_wheel_inverse_kinematics uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd(cmd), .rpm_valid(rpm_valid), .rpm_stall(rpm_stall), .rpm(rpm)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void sin_cos(logic [31:0] ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit     flip;
    z = $signed(ang);
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_N; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic rpm_t wheel_speeds(cmd_t c);
    rpm_t   res;
    longint spin, den, sn, cs, s38, s20, p, mag, q, r;
    logic [15:0] a;
    spin = longint'(center_dist) * longint'(c.turn_rate) * 262144;
    den = (radius == 0 ? 64'd1 : longint'(radius)) * 16777216;
    for (int k = 0; k < 4; k++) begin
      a = wheel_angle[k] + c.heading;
      sin_cos({a, 16'h0}, sn, cs);
      s38 = -sn * longint'(c.vel_x) + cs * longint'(c.vel_y) + spin;
      s20 = floor_shr(s38 + 131072, 18);
      p = s20 * SCALE_Q16;
      mag = p < 0 ? -p : p;
      q = (mag + den / 2) / den;
      r = p < 0 ? -q : q;
      if (r > RPM_MAX) r = RPM_MAX;
      if (r < RPM_MIN) r = RPM_MIN;
      case (k)
        0: res.rpm_0 = r[23:0];
        1: res.rpm_1 = r[23:0];
        2: res.rpm_2 = r[23:0];
        default: res.rpm_3 = r[23:0];
      endcase
    end
    return res;
  endfunction

  // result side: stall pattern and checking
  always @(posedge clk) begin
    if (rst) begin
      rpm_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) stall_hold = ~stall_hold;
      rpm_stall <= stall_hold ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
      if (rpm_valid && !rpm_stall) begin
        if (expected_rpm.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, rpm);
          errors++;
        end else begin
          rpm_t e;
          e = expected_rpm.pop_front();
          if (e.rpm_0 !== rpm.rpm_0)
            $display("%0t: rpm_0 expected %0d actual %0d", $time, e.rpm_0, rpm.rpm_0);
          if (e.rpm_1 !== rpm.rpm_1)
            $display("%0t: rpm_1 expected %0d actual %0d", $time, e.rpm_1, rpm.rpm_1);
          if (e.rpm_2 !== rpm.rpm_2)
            $display("%0t: rpm_2 expected %0d actual %0d", $time, e.rpm_2, rpm.rpm_2);
          if (e.rpm_3 !== rpm.rpm_3)
            $display("%0t: rpm_3 expected %0d actual %0d", $time, e.rpm_3, rpm.rpm_3);
          if (e !== rpm) errors++;
          beats_checked++;
        end
      end
    end
  end

  task automatic send_cmd(cmd_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    expected_rpm.insert(expected_rpm.size(), wheel_speeds(c));
    beats_sent++;
    burst_left--;
  endtask

  task automatic drain;
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_rpm.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ANGLE_0, REG_ANGLE_1, REG_ANGLE_2, REG_ANGLE_3: wheel_angle[idx[1:0]] = val;
      REG_CENTER_DIST: center_dist = val;
      REG_RADIUS: radius = val;
      default: ;
    endcase
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      c.vel_x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      c.vel_y = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      c.turn_rate = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
    end
    return c;
  endfunction

  task automatic test_directed;
    logic signed [15:0] ext [3];
    ext = '{16'sh7fff, 16'sh8000, 16'sh0000};
    foreach (ext[i])
      send_cmd('{vel_x: ext[i], vel_y: 16'sh0, turn_rate: 16'sh0, heading: 16'h0});
    foreach (ext[i])
      send_cmd('{vel_x: 16'sh0, vel_y: ext[i], turn_rate: 16'sh0, heading: 16'h4000});
    foreach (ext[i])
      send_cmd('{vel_x: 16'sh0, vel_y: 16'sh0, turn_rate: ext[i], heading: 16'hffff});
    send_cmd('{vel_x: 16'sh7fff, vel_y: 16'sh7fff, turn_rate: 16'sh7fff, heading: 16'h8000});
    send_cmd('{vel_x: 16'sh8000, vel_y: 16'sh8000, turn_rate: 16'sh8000, heading: 16'hc000});
    // quarter-turn boundaries of the angle fold
    send_cmd('{vel_x: 16'sh0100, vel_y: 16'sh0100, turn_rate: 16'sh0, heading: 16'h2000});
    send_cmd('{vel_x: 16'sh0100, vel_y: 16'sh0100, turn_rate: 16'sh0, heading: 16'h2001});
    send_cmd('{vel_x: 16'sh0100, vel_y: 16'sh0100, turn_rate: 16'sh0, heading: 16'h5fff});
    send_cmd('{vel_x: 16'sh0100, vel_y: 16'shff00, turn_rate: 16'sh1000, heading: 16'h6000});
    drain();
  endtask

  task automatic test_zero_radius;
    write_reg(REG_RADIUS, 16'h0);
    write_reg(REG_CENTER_DIST, 16'hffff);
    repeat (8) send_cmd(rand_cmd());
    drain();
    write_reg(REG_RADIUS, 16'hffff);
    write_reg(REG_CENTER_DIST, 16'h0);
    repeat (8) send_cmd(rand_cmd());
    drain();
  endtask

  task automatic test_random(int n);
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 4; r++)
        write_reg(r[2:0], (ph == 1) ? 16'hffff : (ph == 2) ? 16'h0 : 16'($urandom));
      write_reg(REG_CENTER_DIST, (ph == 1) ? 16'hffff : 16'($urandom_range(0, 1024)));
      write_reg(REG_RADIUS, (ph == 2) ? 16'h1 : 16'($urandom_range(1, 4096)));
      for (int i = 0; i < n / 6; i++) begin
        send_cmd(rand_cmd());
        if (i == n / 12) drain();
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_valid = 1'b0;
    cmd = '0;
    rpm_stall = 1'b0;
    stall_hold = 0;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    burst_left = 0;
    wheel_angle = '{16'd8192, 16'd24576, 16'd40960, 16'd57344};
    center_dist = 16'd256;
    radius = 16'd256;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_radius();
    test_random(1380);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d commands sent, %0d wheel-speed beats checked over 9 register settings",
             beats_sent, beats_checked);
    if (errors == 0 && expected_rpm.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
